@@ rtl/htd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package htd_pkg;

	localparam int LEAF_LIMIT = 256;
	localparam int BITS_PER_BYTE = 8;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_INDEX_W = 2;

	localparam logic [1:0] FUNC_NODE    = 2'd0;
	localparam logic [1:0] FUNC_STREAM  = 2'd1;
	localparam logic [1:0] FUNC_RESTART = 2'd2;

	localparam logic STATUS_BYTE  = 1'b0;
	localparam logic STATUS_ERROR = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROOT_INDEX    = 2'd1;

	localparam logic [23:0] OUTPUT_LENGTH_RESET = 24'd1;
	localparam logic [7:0]  ROOT_INDEX_RESET    = 8'd254;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  node_index;
		logic [15:0] link_zero;
		logic [15:0] link_one;
		logic [7:0]  stream_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       status;
		logic       done_res;
		logic       last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_STEP  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

endpackage

`default_nettype wire

@@ rtl/htd_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module htd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/huffman_tree_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Huffman tree-walk decoder. Node words (func 0) load the tree table, stream words
// (func 1) are decoded least significant bit first, restart words (func 2) and writes
// to the length or root register send the walk back to the root and clear the count and flags.
// A stream word walks one bit per clock through the node RAM while the result side does
// not stall; the registered read makes each lookup depend on the one before. A stream word
// holds the input while the accepting cycle issues the lookup of the current node, the
// step state walks the bits and the flush state hands over its final result; an error or
// a finished count ends the walk early. Node, restart and halted stream words are taken in idle.
// Up to 8 results come out per stream word, the last one marked with last.

module huffman_tree_decoder #(
	parameter int NODE_COUNT = 256
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                item_valid,
	output logic                                     item_ready,
	input  wire htd_pkg::item_t                      item,
	output logic                                     result_valid,
	input  wire logic                                result_ready,
	output htd_pkg::result_t                         result,
	input  wire logic                                cfg_we,
	input  wire logic [htd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [htd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int NW = $clog2(NODE_COUNT);
	localparam logic [16:0] LINK_END = 17'(htd_pkg::LEAF_LIMIT + NODE_COUNT);

	htd_pkg::state_t  state_q;
	logic [2:0]       bit_cnt_q;
	logic [7:0]       shift_q;
	logic [NW-1:0]    cur_q;
	logic             cur_bad_q;
	logic [23:0]      produced_q;
	logic             fin_q;
	logic             fault_q;
	logic [23:0]      len_q;
	logic [7:0]       root_q;
	logic             pend_valid_q;
	htd_pkg::result_t pend_q;
	logic             res_valid_q;
	htd_pkg::result_t res_q;

	logic             accept;
	logic             start;
	logic             node_wr;
	logic             root_bad;
	logic [NW-1:0]    root_node;
	logic [31:0]      rd_data;
	logic             rd_en;
	logic [NW-1:0]    rd_addr;
	logic [15:0]      link;
	logic             is_leaf;
	logic             link_bad;
	logic [NW-1:0]    next_node;
	logic [23:0]      len_eff;
	logic             count_done;
	logic             produce;
	logic             can_push;
	logic             stall;
	logic             step_err;
	logic             step_done;
	logic             terminal;
	logic             advance;
	logic             push;
	htd_pkg::result_t new_res;

	assign item_ready = (state_q == htd_pkg::ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign start      = accept && (item.func == htd_pkg::FUNC_STREAM) && !fin_q && !fault_q;
	assign node_wr    = accept && (item.func == htd_pkg::FUNC_NODE)
	                    && (32'(item.node_index) < NODE_COUNT);

	assign root_bad  = 32'(root_q) >= NODE_COUNT;
	assign root_node = NW'(root_q);

	assign link      = shift_q[0] ? rd_data[31:16] : rd_data[15:0];
	assign is_leaf   = (link[15:8] == 8'd0);
	assign link_bad  = {1'b0, link} >= LINK_END;
	assign next_node = NW'(link - 16'(htd_pkg::LEAF_LIMIT));

	assign len_eff    = (len_q == 24'd0) ? 24'd1 : len_q;
	assign count_done = ({1'b0, produced_q} + 25'd1) >= {1'b0, len_eff};

	assign can_push  = !res_valid_q || result_ready;
	assign step_err  = cur_bad_q || (!is_leaf && link_bad);
	assign step_done = !step_err && is_leaf && count_done;
	assign produce   = cur_bad_q || is_leaf || link_bad;
	assign stall     = produce && pend_valid_q && !can_push;
	assign terminal  = step_err || step_done || (bit_cnt_q == 3'd7);
	assign advance   = (state_q == htd_pkg::ST_STEP) && !stall;
	assign push      = pend_valid_q
	                   && ((advance && produce) || (state_q == htd_pkg::ST_FLUSH && can_push));

	always_comb begin
		new_res          = '0;
		new_res.status   = step_err ? htd_pkg::STATUS_ERROR : htd_pkg::STATUS_BYTE;
		new_res.out_byte = step_err ? 8'd0 : link[7:0];
		new_res.done_res = step_done;
		new_res.last     = 1'b0;
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur_q;
		if (start) begin
			rd_en   = 1'b1;
			rd_addr = cur_q;
		end else if (advance && !terminal) begin
			rd_en   = 1'b1;
			rd_addr = is_leaf ? root_node : next_node;
		end
	end

	htd_ram #(
		.WIDTH (32),
		.DEPTH (NODE_COUNT)
	) u_node_ram (
		.clk     (clk),
		.wr_en   (node_wr),
		.wr_addr (NW'(item.node_index)),
		.wr_data ({item.link_one, item.link_zero}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= htd_pkg::ST_IDLE;
			bit_cnt_q    <= 3'd0;
			cur_q        <= NW'(htd_pkg::ROOT_INDEX_RESET);
			cur_bad_q    <= 32'(htd_pkg::ROOT_INDEX_RESET) >= NODE_COUNT;
			produced_q   <= 24'd0;
			fin_q        <= 1'b0;
			fault_q      <= 1'b0;
			len_q        <= htd_pkg::OUTPUT_LENGTH_RESET;
			root_q       <= htd_pkg::ROOT_INDEX_RESET;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (push) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					htd_pkg::REG_OUTPUT_LENGTH: begin
						len_q      <= cfg_data;
						cur_q      <= root_node;
						cur_bad_q  <= root_bad;
						produced_q <= 24'd0;
						fin_q      <= 1'b0;
						fault_q    <= 1'b0;
					end
					htd_pkg::REG_ROOT_INDEX: begin
						root_q     <= cfg_data[7:0];
						cur_q      <= NW'(cfg_data[7:0]);
						cur_bad_q  <= 32'(cfg_data[7:0]) >= NODE_COUNT;
						produced_q <= 24'd0;
						fin_q      <= 1'b0;
						fault_q    <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			unique case (state_q)
				htd_pkg::ST_IDLE: begin
					if (accept && item.func == htd_pkg::FUNC_RESTART) begin
						cur_q      <= root_node;
						cur_bad_q  <= root_bad;
						produced_q <= 24'd0;
						fin_q      <= 1'b0;
						fault_q    <= 1'b0;
					end
					if (start) begin
						bit_cnt_q <= 3'd0;
						state_q   <= htd_pkg::ST_STEP;
					end
				end
				htd_pkg::ST_STEP: begin
					if (!stall) begin
						if (produce) begin
							pend_valid_q <= 1'b1;
						end
						if (step_err) begin
							fault_q <= 1'b1;
						end else if (is_leaf) begin
							produced_q <= produced_q + 24'd1;
							cur_q      <= root_node;
							cur_bad_q  <= root_bad;
							fin_q      <= count_done;
						end else begin
							cur_q <= next_node;
						end
						bit_cnt_q <= bit_cnt_q + 3'd1;
						if (terminal) begin
							state_q <= htd_pkg::ST_FLUSH;
						end
					end
				end
				htd_pkg::ST_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= htd_pkg::ST_IDLE;
					end else if (can_push) begin
						pend_valid_q <= 1'b0;
						state_q      <= htd_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= htd_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= item.stream_byte;
		end else if (advance) begin
			shift_q <= {1'b0, shift_q[7:1]};
		end
		if (advance && produce) begin
			pend_q <= new_res;
		end
		if (push) begin
			res_q <= '{out_byte: pend_q.out_byte, status: pend_q.status,
				done_res: pend_q.done_res, last: (state_q == htd_pkg::ST_FLUSH)};
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == htd_pkg::ST_IDLE) |-> !pend_valid_q)
		else $error("pending result left over in idle");

	a_walk_not_halted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == htd_pkg::ST_STEP) |-> (!fin_q && !fault_q))
		else $error("walk running while halted");

	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == htd_pkg::STATUS_ERROR)
		|-> (!result.done_res && result.last && result.out_byte == 8'd0))
		else $error("malformed error word");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.done_res) |-> result.last)
		else $error("done word not marked last");

endmodule

`default_nettype wire

@@ tb/htd_decode_monitor.sv @@
`timescale 1ns / 1ps

module htd_decode_monitor
	import htd_pkg::*;
#(
	parameter int NODE_COUNT = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  logic                   item_ready,
	input  item_t                  item,
	input  logic                   result_valid,
	input  logic                   result_ready,
	input  result_t                result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     waiting
);

	logic [15:0] zero_link [NODE_COUNT];
	logic [15:0] one_link  [NODE_COUNT];
	int          walk_node;
	int          produced;
	bit          finished;
	bit          faulted;
	logic [23:0] length_reg;
	logic [7:0]  root_reg;
	result_t     decoded_q [$];

	function automatic void rewind();
		walk_node = root_reg;
		produced = 0;
		finished = 1'b0;
		faulted = 1'b0;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s expected %0h got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t     want;
		logic [15:0] link;
		int          child;
		int          made;
		bit          done;
		if (!arst_n) begin
			length_reg = OUTPUT_LENGTH_RESET;
			root_reg = ROOT_INDEX_RESET;
			rewind();
			decoded_q.delete();
			fail_count = 0;
			waiting = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (decoded_q.size() == 0) begin
					$error("result word with nothing expected: out_byte %0h status %0h",
						result.out_byte, result.status);
					fail_count++;
				end else begin
					want = decoded_q.pop_front();
					check_field("out_byte", want.out_byte, result.out_byte);
					check_field("status", 8'(want.status), 8'(result.status));
					check_field("done_res", 8'(want.done_res), 8'(result.done_res));
					check_field("last", 8'(want.last), 8'(result.last));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_OUTPUT_LENGTH: begin
						length_reg = cfg_data;
						rewind();
					end
					REG_ROOT_INDEX: begin
						root_reg = cfg_data[7:0];
						rewind();
					end
					default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				case (item.func)
					FUNC_NODE: begin
						if (int'(item.node_index) < NODE_COUNT) begin
							zero_link[item.node_index] = item.link_zero;
							one_link[item.node_index] = item.link_one;
						end
					end
					FUNC_RESTART: rewind();
					FUNC_STREAM: begin
						made = 0;
						if (!finished && !faulted) begin
							for (int b = 0; b < BITS_PER_BYTE; b++) begin
								if (walk_node >= NODE_COUNT) begin
									decoded_q.push_back('{out_byte: 8'h00, status: STATUS_ERROR,
										done_res: 1'b0, last: 1'b0});
									made++;
									faulted = 1'b1;
									break;
								end
								link = item.stream_byte[b] ? one_link[walk_node] : zero_link[walk_node];
								if (int'(link) < LEAF_LIMIT) begin
									produced++;
									done = produced >= int'(length_reg);
									decoded_q.push_back('{out_byte: link[7:0], status: STATUS_BYTE,
										done_res: done, last: 1'b0});
									made++;
									walk_node = root_reg;
									if (done) begin
										finished = 1'b1;
										break;
									end
								end else begin
									child = int'(link) - LEAF_LIMIT;
									if (child >= NODE_COUNT) begin
										decoded_q.push_back('{out_byte: 8'h00, status: STATUS_ERROR,
											done_res: 1'b0, last: 1'b0});
										made++;
										faulted = 1'b1;
										break;
									end
									walk_node = child;
								end
							end
						end
						if (made != 0)
							decoded_q[decoded_q.size() - 1].last = 1'b1;
					end
					default: ;
				endcase
			end
			waiting = decoded_q.size();
		end
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import htd_pkg::*;

	localparam int NODE_COUNT = 256;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 32;
	localparam int PHASE_WORDS = 41;
	localparam int PHASES = 10;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_PRESSURE} phase_e;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_ready;
	item_t                  item = '0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	result_t                result;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	phase_e                 phase = PH_FREE;
	int                     hold_cycles = 0;
	int                     fail_count;
	int                     waiting;
	bit                     loaded [NODE_COUNT];
	int                     loaded_q [$];

	always #5 clk = ~clk;

	huffman_tree_decoder #(
		.NODE_COUNT(NODE_COUNT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	htd_decode_monitor #(
		.NODE_COUNT(NODE_COUNT)
	) i_monitor (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.waiting(waiting)
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			hold_cycles <= 0;
		end else begin
			if (phase != PH_PRESSURE)
				hold_cycles <= 0;
			else if (hold_cycles < HOLD_CYCLES)
				hold_cycles <= hold_cycles + 1;
			case (phase)
				PH_RECV_STALL: result_ready <= $urandom_range(0, 99) >= 74;
				PH_BOTH:       result_ready <= $urandom_range(0, 99) >= 34;
				PH_PRESSURE:   result_ready <= hold_cycles >= HOLD_CYCLES;
				default:       result_ready <= 1'b1;
			endcase
		end
	end

	initial begin
		#5_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic item_t make_word(logic [1:0] func, logic [7:0] idx,
		logic [15:0] l0, logic [15:0] l1, logic [7:0] data);
		item_t w;
		w.func = func;
		w.node_index = idx;
		w.link_zero = l0;
		w.link_one = l1;
		w.stream_byte = data;
		return w;
	endfunction

	function automatic item_t other_word(logic [1:0] func);
		return make_word(func, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
	endfunction

	function automatic item_t stream_word(logic [7:0] data);
		return make_word(FUNC_STREAM, 8'($urandom), 16'($urandom), 16'($urandom), data);
	endfunction

	// leaf, link to a loaded node (or self), or a link past the table
	function automatic logic [15:0] rand_link(logic [7:0] self);
		int r;
		int k;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 16'($urandom_range(0, LEAF_LIMIT - 1));
		if (r < 98) begin
			k = $urandom_range(0, loaded_q.size());
			return 16'(LEAF_LIMIT + (k == loaded_q.size() ? int'(self) : loaded_q[k]));
		end
		return 16'($urandom_range(LEAF_LIMIT + NODE_COUNT, 16'hFFFF));
	endfunction

	task automatic send_word(input item_t w);
		while ((phase == PH_SEND_IDLE && $urandom_range(0, 99) < 74) ||
			(phase == PH_BOTH && $urandom_range(0, 99) < 34)) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic load_node(input logic [7:0] idx, input logic [15:0] l0, input logic [15:0] l1);
		send_word(make_word(FUNC_NODE, idx, l0, l1, 8'($urandom)));
		if (!loaded[idx]) begin
			loaded[idx] = 1'b1;
			loaded_q.push_back(idx);
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int          r;
		int          budget;
		int          streams;
		logic [7:0]  idx;
		logic [23:0] len_word;
		logic [23:0] root_word;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_node(8'd254, 16'(LEAF_LIMIT + 253), 16'h00FF);
		load_node(8'd253, 16'h0000, 16'(LEAF_LIMIT + 254));
		load_node(8'd0, 16'h005A, 16'hFFFF);
		load_node(8'd255, 16'(LEAF_LIMIT + 255), 16'h00A5);
		send_word(stream_word(8'hFF));
		send_word(stream_word(8'h3C));
		send_word(other_word(FUNC_UNUSED));
		send_word(other_word(FUNC_RESTART));
		send_word(stream_word(8'h00));
		settle();
		write_reg(REG_OUTPUT_LENGTH, 24'd0);
		send_word(stream_word(8'h01));
		settle();
		write_reg(REG_OUTPUT_LENGTH, 24'hFFFFFF);
		write_reg(REG_ROOT_INDEX, 24'hFFFF00);
		send_word(stream_word(8'h00));
		send_word(stream_word(8'h02));
		settle();
		write_reg(REG_SPARE_LO, 24'hFFFFFF);
		write_reg(REG_SPARE_HI, 24'h000001);
		send_word(stream_word(8'h00));
		send_word(other_word(FUNC_RESTART));
		send_word(stream_word(8'h00));
		settle();
		write_reg(REG_ROOT_INDEX, 24'd255);
		send_word(stream_word(8'h80));
		send_word(stream_word(8'h7F));

		for (int p = 0; p < PHASES; p++) begin
			settle();
			phase <= phase_e'(p % 5);
			r = $urandom_range(0, 99);
			if (r < 30)
				len_word = 24'($urandom_range(1, 3));
			else if (r < 70)
				len_word = 24'($urandom_range(4, 60));
			else if (r < 88)
				len_word = 24'hFFFFFF;
			else
				len_word = 24'($urandom);
			root_word = {16'($urandom), 8'(loaded_q[$urandom_range(0, loaded_q.size() - 1)])};
			if ($urandom_range(0, 1)) begin
				write_reg(REG_OUTPUT_LENGTH, len_word);
				write_reg(REG_ROOT_INDEX, root_word);
			end else begin
				write_reg(REG_ROOT_INDEX, root_word);
				write_reg(REG_OUTPUT_LENGTH, len_word);
			end
			streams = 0;
			budget = $urandom_range(1, 8);
			repeat (PHASE_WORDS) begin
				r = $urandom_range(0, 99);
				if (streams >= budget || r < 3) begin
					send_word(other_word(FUNC_RESTART));
					streams = 0;
					budget = $urandom_range(1, 8);
				end else if (r < 10) begin
					idx = 8'($urandom_range(0, NODE_COUNT - 1));
					load_node(idx, rand_link(idx), rand_link(idx));
				end else if (r < 13) begin
					send_word(other_word(FUNC_UNUSED));
				end else begin
					send_word(stream_word(8'($urandom)));
					streams++;
				end
			end
		end

		settle();
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
